@@ sv/spectral_peak_interpolator_macros.svh @@
`ifndef SPECTRAL_PEAK_INTERPOLATOR_MACROS_SVH
`define SPECTRAL_PEAK_INTERPOLATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define SPKINT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("spkint assertion failed");
`define SPKINT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("spkint assertion failed");
`else
`define SPKINT_ASSERT(lbl, clk, rst_n, prop)
`define SPKINT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/spkint_pkg.sv @@
package spkint_pkg;

	localparam int MAG_W      = 16;
	localparam int BIN_W      = 7;
	localparam int FREQ_W     = 23;
	localparam int RATE_W     = 16;
	localparam int OUT_DATA_W = 48;
	localparam int DVD_W      = 31;
	localparam int DVS_W      = 17;
	localparam int REM_W      = DVS_W + 1;
	localparam int CNT_W      = $clog2(DVD_W);
	localparam int Q_W        = 7;
	localparam int POS_W      = BIN_W + 10;
	localparam int POSM_W     = BIN_W + 8;

	localparam int TRANSFORM_SIZE_DEF = 256;

	localparam logic [RATE_W-1:0] RATE_RESET = 16'd15037;
	localparam logic [FREQ_W-1:0] FREQ_MAX   = 23'h7FFFFF;

	typedef enum logic [2:0] {
		ST_SCAN,
		ST_DIV1,
		ST_MUL,
		ST_SCALE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic scan_en;
		logic frame_end;
		logic div_step;
		logic mul_en;
		logic scale_en;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic div_last;
	} dp_stat_t;

endpackage

@@ sv/spkint_dp.sv @@
module spkint_dp #(
	parameter int TRANSFORM_SIZE = spkint_pkg::TRANSFORM_SIZE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  spkint_pkg::dp_cmd_t               cmd,
	output spkint_pkg::dp_stat_t              stat,
	input  logic                              cfg_wr_en,
	input  logic [spkint_pkg::RATE_W-1:0]     cfg_wr_data,
	input  logic [spkint_pkg::MAG_W-1:0]      magnitude,
	output logic                              peak_found,
	output logic [spkint_pkg::BIN_W-1:0]      peak_bin,
	output logic [spkint_pkg::MAG_W-1:0]      peak_magnitude,
	output logic [spkint_pkg::FREQ_W-1:0]     frequency_q8
);
	import spkint_pkg::*;

	localparam int DIVISOR  = TRANSFORM_SIZE - 1;
	localparam int SCALE_SH = DVD_W + $clog2(DIVISOR);
	localparam int RECIP_W  = DVD_W + 1;
	localparam longint unsigned RECIP_FULL =
		((64'd1 << SCALE_SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

	logic [RATE_W-1:0] rate_q;
	logic [MAG_W-1:0]  older_q, prev_q, best_mag_q, best_l_q, best_r_q;
	logic [BIN_W-1:0]  bin_q, best_idx_q;

	logic              is_peak;
	logic [MAG_W-1:0]  nb_mag, nb_l, nb_r, abs_diff;
	logic [BIN_W-1:0]  nb_idx;
	logic [REM_W-1:0]  den;

	logic              found_q, sign_q;
	logic [BIN_W-1:0]  job_idx_q;
	logic [MAG_W-1:0]  job_mag_q;

	logic [DVD_W-1:0]  dvd_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [REM_W-1:0]  rem_q, rem_sh;
	logic [CNT_W-1:0]  cnt_q;
	logic              ge;

	logic [POS_W-1:0]  dq_ext, pos;
	logic [POSM_W-1:0] pos_mag;
	logic [DVD_W-1:0]  prod;

	logic [DVD_W+RECIP_W-1:0] scaled;
	logic [DVD_W-1:0]         quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
		end else if (cfg_wr_en) begin
			rate_q <= cfg_wr_data;
		end
	end

	always_comb begin
		is_peak = (bin_q >= BIN_W'(2)) && (older_q < prev_q) && (prev_q > magnitude) &&
			(prev_q > best_mag_q);
		nb_mag  = is_peak ? prev_q : best_mag_q;
		nb_l    = is_peak ? older_q : best_l_q;
		nb_r    = is_peak ? magnitude : best_r_q;
		nb_idx  = is_peak ? bin_q - BIN_W'(1) : best_idx_q;
		abs_diff = (nb_l > nb_r) ? nb_l - nb_r : nb_r - nb_l;
		den = {1'b0, nb_mag, 1'b0} - {2'b0, nb_l} - {2'b0, nb_r};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q    <= '0;
			prev_q     <= '0;
			bin_q      <= '0;
			best_mag_q <= '0;
			best_l_q   <= '0;
			best_r_q   <= '0;
			best_idx_q <= '0;
		end else if (cmd.scan_en) begin
			if (cmd.frame_end) begin
				older_q    <= '0;
				prev_q     <= '0;
				bin_q      <= '0;
				best_mag_q <= '0;
				best_l_q   <= '0;
				best_r_q   <= '0;
				best_idx_q <= '0;
			end else begin
				older_q    <= prev_q;
				prev_q     <= magnitude;
				bin_q      <= bin_q + BIN_W'(1);
				best_mag_q <= nb_mag;
				best_l_q   <= nb_l;
				best_r_q   <= nb_r;
				best_idx_q <= nb_idx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.frame_end) begin
			found_q   <= (nb_mag != '0);
			sign_q    <= (nb_r > nb_l);
			job_idx_q <= nb_idx;
			job_mag_q <= nb_mag;
		end
	end

	always_comb begin
		rem_sh = {rem_q[REM_W-2:0], dvd_q[DVD_W-1]};
		ge     = (rem_sh >= {1'b0, dvs_q});
		dq_ext = {{(POS_W-Q_W){1'b0}}, dvd_q[Q_W-1:0]};
		pos    = {2'b0, job_idx_q, 8'b0} + (sign_q ? dq_ext : (~dq_ext + POS_W'(1)));
		pos_mag = pos[POS_W-1] ? '0 : pos[POSM_W-1:0];
		prod   = {{(DVD_W-POSM_W){1'b0}}, pos_mag} * {{(DVD_W-RATE_W){1'b0}}, rate_q};
		scaled = {{RECIP_W{1'b0}}, dvd_q} * {{DVD_W{1'b0}}, RECIP};
		quo    = DVD_W'(scaled >> SCALE_SH);
	end

	always_ff @(posedge clk) begin
		if (cmd.frame_end) begin
			dvd_q <= {{(DVD_W-MAG_W-7){1'b0}}, abs_diff, 7'b0};
			dvs_q <= den[DVS_W-1:0];
			rem_q <= '0;
		end else if (cmd.mul_en) begin
			dvd_q <= prod;
		end else if (cmd.scale_en) begin
			dvd_q <= quo;
		end else if (cmd.div_step) begin
			rem_q <= ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.frame_end) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	assign stat.div_last = (cnt_q == CNT_W'(DVD_W - 1));

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			peak_found     <= found_q;
			peak_bin       <= found_q ? job_idx_q : '0;
			peak_magnitude <= found_q ? job_mag_q : '0;
			if (!found_q) begin
				frequency_q8 <= '0;
			end else if (dvd_q > {{(DVD_W-FREQ_W){1'b0}}, FREQ_MAX}) begin
				frequency_q8 <= FREQ_MAX;
			end else begin
				frequency_q8 <= dvd_q[FREQ_W-1:0];
			end
		end
	end

endmodule

@@ sv/spkint_ctrl.sv @@
`include "spectral_peak_interpolator_macros.svh"

module spkint_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tlast,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output spkint_pkg::dp_cmd_t   cmd,
	input  spkint_pkg::dp_stat_t  stat
);
	import spkint_pkg::*;

	state_t state_q, state_d;
	logic   m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SCAN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_SCAN: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.scan_en = 1'b1;
					if (s_tlast) begin
						cmd.frame_end = 1'b1;
						state_d       = ST_DIV1;
					end
				end
			end
			ST_DIV1: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale_en = 1'b1;
				state_d      = ST_DONE;
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_SCAN;
				end
			end
			default: begin
				state_d = ST_SCAN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;

	`SPKINT_ASSERT_NEXT(a_last_starts_div, clk, arst_n, s_tvalid && s_tready && s_tlast, state_q == ST_DIV1)
	`SPKINT_ASSERT_NEXT(a_div1_to_mul, clk, arst_n, state_q == ST_DIV1 && stat.div_last, state_q == ST_MUL)
	`SPKINT_ASSERT(a_result_from_done, clk, arst_n, $rose(m_tvalid_q) |-> $past(state_q) == ST_DONE)
	`SPKINT_ASSERT_NEXT(a_done_holds, clk, arst_n, state_q == ST_DONE && m_tvalid_q && !m_tready, state_q == ST_DONE)

endmodule

@@ sv/spectral_peak_interpolator.sv @@
// Spectral peak finder with parabolic refinement. Magnitudes stream in one bin
// per request, bin 0 first, with tlast on the final bin, and are taken one per
// cycle while scanning. After the last bin the block stops taking requests: an
// iterative radix-2 divider runs 31 steps for the parabolic offset, a multiply
// step scales the refined bin position by sample_rate_hz, a scale step divides
// by TRANSFORM_SIZE-1 with a reciprocal multiply, and a final step moves the
// result to the output register. That last step waits while the previous result
// has not been taken; otherwise scanning of the next frame starts while a result
// waits. One result comes per frame; peak_found (tuser) is 0 and all fields
// are 0 when the frame had no interior strict local maximum. The frequency is
// in Hz with 8 fraction bits and saturates at its full scale.
module spectral_peak_interpolator #(
	parameter int TRANSFORM_SIZE = spkint_pkg::TRANSFORM_SIZE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [spkint_pkg::RATE_W-1:0]      cfg_wr_data,     // sample_rate_hz
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [spkint_pkg::MAG_W-1:0]       s_tdata,         // magnitude
	input  logic                               s_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// peak_bin, peak_magnitude, frequency_q8
	output logic [spkint_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic                               m_tuser          // peak_found
);
	import spkint_pkg::*;

	dp_cmd_t            cmd;
	dp_stat_t           stat;
	logic [BIN_W-1:0]   peak_bin;
	logic [MAG_W-1:0]   peak_magnitude;
	logic [FREQ_W-1:0]  frequency_q8;

	spkint_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	spkint_dp #(
		.TRANSFORM_SIZE (TRANSFORM_SIZE)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.magnitude      (s_tdata),
		.peak_found     (m_tuser),
		.peak_bin       (peak_bin),
		.peak_magnitude (peak_magnitude),
		.frequency_q8   (frequency_q8)
	);

	assign m_tdata = {{(OUT_DATA_W-FREQ_W-MAG_W-BIN_W){1'b0}}, frequency_q8, peak_magnitude,
		peak_bin};

endmodule
